// File: hw/rtl/ssd_pkg.sv
// Shared types and constants for the start-string / stop-byte deframer.
// No dependencies; used by every module under hw/rtl.
package ssd_pkg;

	localparam int MAX_MESSAGE   = 256;
	localparam int MAX_START_LEN = 4;

	localparam int CNT_W  = $clog2(MAX_MESSAGE);
	localparam int SYNC_W = $clog2(MAX_START_LEN + 1);
	localparam int OVF_LIMIT = MAX_MESSAGE - 2;

	typedef enum logic [1:0] {
		REG_START_LENGTH = 2'd0,
		REG_START_BYTES  = 2'd1,
		REG_STOP_BYTE    = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_SYNCING   = 2'd0,
		ST_RECEIVING = 2'd1,
		ST_COMPLETE  = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  start_length;
		logic [31:0] start_bytes;
		logic [7:0]  stop_byte;
	} cfg_t;

	typedef struct packed {
		status_t    status;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       end_of_message;
	} result_t;

endpackage

// File: hw/rtl/ssd_cfg.sv
// Configuration register file for the deframer.
// Depends on ssd_pkg.
module ssd_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output ssd_pkg::cfg_t cfg
);

	ssd_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_length <= 3'd1;
			cfg_q.start_bytes  <= 32'd0;
			cfg_q.stop_byte    <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ssd_pkg::REG_START_LENGTH: cfg_q.start_length <= cfg_data[2:0];
				ssd_pkg::REG_START_BYTES:  cfg_q.start_bytes  <= cfg_data;
				ssd_pkg::REG_STOP_BYTE:    cfg_q.stop_byte    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/ssd_core.sv
// Framing state (sync match count, receive mode, byte count) and the
// per-byte result logic. Depends on ssd_pkg.
module ssd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  ssd_pkg::cfg_t    cfg,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	output ssd_pkg::result_t res
);

	logic                       receiving_q;
	logic [ssd_pkg::SYNC_W-1:0] sync_count_q;
	logic [ssd_pkg::CNT_W-1:0]  byte_count_q;

	logic                       receiving_d;
	logic [ssd_pkg::SYNC_W-1:0] sync_count_d;
	logic [ssd_pkg::CNT_W-1:0]  byte_count_d;

	logic [ssd_pkg::SYNC_W-1:0] eff_len;
	logic [ssd_pkg::SYNC_W-1:0] pos;
	logic [ssd_pkg::SYNC_W-1:0] pos_inc;
	logic [7:0]                 start_byte;
	logic [ssd_pkg::CNT_W:0]    count_inc;

	always_comb begin
		// clamp length to 1..MAX_START_LEN
		if (cfg.start_length == 3'd0)
			eff_len = ssd_pkg::SYNC_W'(1);
		else if (32'(cfg.start_length) > ssd_pkg::MAX_START_LEN)
			eff_len = ssd_pkg::SYNC_W'(ssd_pkg::MAX_START_LEN);
		else
			eff_len = ssd_pkg::SYNC_W'(cfg.start_length);

		// count may be stale after a length change
		pos = (sync_count_q >= eff_len) ? '0 : sync_count_q;
		pos_inc = pos + ssd_pkg::SYNC_W'(1);

		// positions past the packed word compare as zero
		if (32'(pos) >= 32'd4)
			start_byte = 8'd0;
		else
			start_byte = cfg.start_bytes[8*pos[1:0] +: 8];

		count_inc = {1'b0, byte_count_q} + (ssd_pkg::CNT_W+1)'(1);

		res = '0;
		res.status   = ssd_pkg::ST_SYNCING;
		receiving_d  = receiving_q;
		sync_count_d = sync_count_q;
		byte_count_d = byte_count_q;

		if (!receiving_q) begin
			if (rx_byte == start_byte && pos_inc >= eff_len) begin
				sync_count_d = '0;
				byte_count_d = '0;
				receiving_d  = 1'b1;
				res.status   = ssd_pkg::ST_RECEIVING;
			end else if (rx_byte == start_byte) begin
				sync_count_d = pos_inc;
			end else begin
				sync_count_d = '0;
			end
		end else begin
			res.payload_valid = 1'b1;
			res.payload_byte  = rx_byte;
			res.payload_index = 8'(byte_count_q);
			byte_count_d      = byte_count_q + ssd_pkg::CNT_W'(1);
			if (rx_byte == cfg.stop_byte) begin
				res.status         = ssd_pkg::ST_COMPLETE;
				res.end_of_message = 1'b1;
			end else if (32'(count_inc) >= ssd_pkg::OVF_LIMIT) begin
				res.status         = ssd_pkg::ST_OVERFLOW;
				res.end_of_message = 1'b1;
			end else begin
				res.status = ssd_pkg::ST_RECEIVING;
			end
			if (res.end_of_message) begin
				byte_count_d = '0;
				receiving_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q  <= 1'b0;
			sync_count_q <= '0;
			byte_count_q <= '0;
		end else if (step) begin
			receiving_q  <= receiving_d;
			sync_count_q <= sync_count_d;
			byte_count_q <= byte_count_d;
		end
	end

endmodule

// File: hw/rtl/start_string_stop_byte_deframer.sv
// Top level of the start-string / stop-byte deframer: config registers,
// framing core and the result register. Depends on ssd_pkg, ssd_cfg, ssd_core.
//
//   channel  signals                       direction  word
//   rx       rx_valid rx_stall rx_byte     in         one received byte
//   res      res_valid res_stall fields    out        one result per byte
//   cfg      cfg_valid cfg_ready index/data in        one register write
//
// One byte per cycle while rx_stall is low: the framing state updates in the
// accept cycle and the result shows in the result register the next cycle.
// rx_stall is high only while a result waits and res_stall is high.
// Reset clears the framing state and loads the register defaults.
// cfg_ready is always high.
module start_string_stop_byte_deframer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rx_valid,
	output logic            rx_stall,
	input  logic [7:0]      rx_byte,
	output logic            res_valid,
	input  logic            res_stall,
	output logic [1:0]      status,
	output logic            payload_valid,
	output logic [7:0]      payload_byte,
	output logic [7:0]      payload_index,
	output logic            end_of_message,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data
);

	ssd_pkg::cfg_t    cfg;
	ssd_pkg::result_t res;
	ssd_pkg::result_t res_q;
	logic             res_valid_q;
	logic             step;

	assign rx_stall = res_valid_q && res_stall;
	assign step     = rx_valid && !rx_stall;

	ssd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ssd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.rx_byte (rx_byte),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign res_valid      = res_valid_q;
	assign status         = res_q.status;
	assign payload_valid  = res_q.payload_valid;
	assign payload_byte   = res_q.payload_byte;
	assign payload_index  = res_q.payload_index;
	assign end_of_message = res_q.end_of_message;

endmodule

// File: tb/ssd_checker.sv
// Checker for the start-string / stop-byte deframer: watches the rx, res and cfg
// channels, predicts each result word and compares it. Depends on ssd_pkg.
module ssd_checker
	import ssd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [1:0]  status,
	input  logic        payload_valid,
	input  logic [7:0]  payload_byte,
	input  logic [7:0]  payload_index,
	input  logic        end_of_message,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t       regs;
	logic       in_msg;
	logic [2:0] match_cnt;
	logic [7:0] msg_len;
	result_t    frames_due[$];
	result_t    due;
	int         errs;

	function automatic result_t deframe(input logic [7:0] b);
		result_t r;
		int len;
		logic [7:0] want;
		r = '0;
		r.status = ST_SYNCING;
		if (!in_msg) begin
			len = regs.start_length;
			if (len == 0)
				len = 1;
			if (len > MAX_START_LEN)
				len = MAX_START_LEN;
			if (match_cnt >= len)
				match_cnt = '0;
			want = (match_cnt < 4) ? regs.start_bytes[8*match_cnt +: 8] : 8'h00;
			// a mismatch drops the count without retrying the byte at position 0
			match_cnt = (b == want) ? match_cnt + 3'd1 : 3'd0;
			if (match_cnt >= len) begin
				match_cnt = '0;
				msg_len = '0;
				in_msg = 1'b1;
				r.status = ST_RECEIVING;
			end
		end else begin
			r.payload_valid = 1'b1;
			r.payload_byte = b;
			r.payload_index = msg_len;
			msg_len = msg_len + 8'd1;
			// stop byte wins over overflow on the same word
			if (b == regs.stop_byte) begin
				r.status = ST_COMPLETE;
				r.end_of_message = 1'b1;
			end else if (int'(msg_len) >= OVF_LIMIT) begin
				r.status = ST_OVERFLOW;
				r.end_of_message = 1'b1;
			end else begin
				r.status = ST_RECEIVING;
			end
			if (r.end_of_message) begin
				msg_len = '0;
				in_msg = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.start_length = 3'd1;
			regs.start_bytes = 32'd0;
			regs.stop_byte = 8'd10;
			in_msg = 1'b0;
			match_cnt = '0;
			msg_len = '0;
			frames_due.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (frames_due.size() == 0) begin
					$error("result word with no expectation waiting");
					errs++;
				end else begin
					due = frames_due.pop_front();
					check_field("status", 8'(due.status), 8'(status));
					check_field("payload_valid", 8'(due.payload_valid), 8'(payload_valid));
					check_field("payload_byte", due.payload_byte, payload_byte);
					check_field("payload_index", due.payload_index, payload_index);
					check_field("end_of_message", 8'(due.end_of_message),
						8'(end_of_message));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_START_LENGTH: regs.start_length = cfg_data[2:0];
					REG_START_BYTES:  regs.start_bytes = cfg_data;
					REG_STOP_BYTE:    regs.stop_byte = cfg_data[7:0];
					default: ;
				endcase
			end
			if (rx_valid && !rx_stall)
				frames_due.push_back(deframe(rx_byte));
			pending <= frames_due.size();
			fail_count <= errs;
		end
	end

endmodule

// File: tb/start_string_stop_byte_deframer_test.sv
// Testbench top for the start-string / stop-byte deframer: clock, reset, byte
// and register stimulus, receiver stalls and the verdict. Depends on ssd_pkg,
// ssd_checker and the deframer RTL.
module start_string_stop_byte_deframer_test;
	import ssd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_stall;
	logic [7:0]  rx_byte;
	logic        res_valid;
	logic        res_stall;
	logic [1:0]  status;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic        end_of_message;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fail_count;
	int          pending;

	int          rx_idle_pct;
	int          stall_pct;
	int          hold_req;
	int          hold_ack;
	int          sent;
	int          quiet = 0;
	int          eff_len;
	logic [31:0] cur_start;
	logic [7:0]  cur_stop;

	start_string_stop_byte_deframer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.status         (status),
		.payload_valid  (payload_valid),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.end_of_message (end_of_message),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	ssd_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.status         (status),
		.payload_valid  (payload_valid),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.end_of_message (end_of_message),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		res_stall <= 1'b0;
		hold_ack = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_ack) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_ack++;
			end else begin
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && !rx_stall) || (res_valid && !res_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// leaves rx_valid high so back-to-back words need no second assignment
	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < rx_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_config(input logic [2:0] len, input logic [31:0] sb,
			input logic [7:0] sp);
		drain();
		write_reg(REG_START_LENGTH, {29'd0, len});
		write_reg(REG_START_BYTES, sb);
		write_reg(REG_STOP_BYTE, {24'd0, sp});
		if ($urandom_range(0, 1))
			write_reg(REG_SPARE, $urandom());
		cfg_valid <= 1'b0;
		eff_len = (len == 0) ? 1 : (len > MAX_START_LEN) ? MAX_START_LEN : int'(len);
		cur_start = sb;
		cur_stop = sp;
	endtask

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == cur_stop)
			b ^= 8'h01;
		return b;
	endfunction

	task automatic send_start(input int count);
		for (int i = 0; i < count; i++)
			put_byte(cur_start[8*i +: 8]);
	endtask

	// 253 body bytes, then either the stop byte or one more body byte (overflow)
	task automatic long_frame(input bit stop_at_limit);
		put_byte(cur_stop);
		send_start(eff_len);
		for (int i = 0; i < OVF_LIMIT - 1; i++)
			put_byte(body_byte());
		put_byte(stop_at_limit ? cur_stop : body_byte());
	endtask

	task automatic traffic(input int quota);
		int stop_at;
		int kind;
		stop_at = sent + quota;
		while (sent < stop_at) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				send_start(eff_len);
				repeat ($urandom_range(0, 12)) put_byte(body_byte());
				put_byte(cur_stop);
			end else if (kind < 9) begin
				send_start($urandom_range(0, eff_len - 1));
				put_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		logic [7:0] defaults_run[] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h01,
			8'h0A, 8'h0A, 8'h00, 8'h0A};
		logic [7:0] resync_run[] = '{8'h01, 8'h02, 8'h01, 8'h02, 8'h03, 8'h04,
			8'h01, 8'h02, 8'h03, 8'h04, 8'hFF, 8'h00};

		arst_n <= 1'b0;
		rx_valid <= 1'b0;
		rx_byte <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= REG_START_LENGTH;
		cfg_data <= 32'd0;
		rx_idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		sent = 0;
		eff_len = 1;
		cur_start = 32'd0;
		cur_stop = 8'd10;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: one-byte start of 0x00, stop 0x0A, stop straight after sync
		foreach (defaults_run[i])
			put_byte(defaults_run[i]);

		// four-byte start: a mismatch mid-string must not be retried as a first byte
		set_config(3'd4, 32'h0403_0201, 8'h00);
		foreach (resync_run[i])
			put_byte(resync_run[i]);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_config(3'd4, 32'hFFFF_FFFF, 8'h00);
				1: set_config(3'd0, 32'h0000_0000, 8'hFF);
				2: set_config(3'd7, 32'h5A3C_C3A5, 8'h7E);
				3: set_config(3'd1, $urandom(), 8'($urandom_range(0, 255)));
				5: set_config(3'd2, 32'h0000_D4B2, 8'h55);
				default: set_config(3'($urandom_range(0, 7)), $urandom(),
					8'($urandom_range(0, 255)));
			endcase
			case (p % 4)
				0: begin rx_idle_pct = 0;  stall_pct = 0;  end
				1: begin rx_idle_pct = 58; stall_pct = 0;  end
				2: begin rx_idle_pct = 0;  stall_pct = 58; end
				default: begin rx_idle_pct = 17; stall_pct = 17; end
			endcase
			if (p == 0)
				hold_req++;
			if (p == 2)
				long_frame(1'b0);
			if (p == 5)
				long_frame(1'b1);
			traffic(75);
		end

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
